// File: hw/rtl/sng_pkg.sv
// Package for the sidechain noise gate: payload structs, controller command struct and constants.
// Used by the controller, the datapath and the top level. Depends on nothing.
package sng_pkg;

  localparam int SW = 24;
  localparam int FB = 16;
  localparam int YW = SW + 4;
  localparam int NUM_REGS = 8;

  localparam logic [2:0] REG_BP_GAIN   = 3'd0;
  localparam logic [2:0] REG_BP_FB     = 3'd1;
  localparam logic [2:0] REG_ATTACK    = 3'd2;
  localparam logic [2:0] REG_RELEASE   = 3'd3;
  localparam logic [2:0] REG_HOLD      = 3'd4;
  localparam logic [2:0] REG_THRESHOLD = 3'd5;
  localparam logic [2:0] REG_FLOOR     = 3'd6;
  localparam logic [2:0] REG_MIX       = 3'd7;

  typedef struct packed {
    logic signed [SW-1:0] main_left;
    logic signed [SW-1:0] main_right;
    logic signed [SW-1:0] side_left;
    logic signed [SW-1:0] side_right;
    logic                 block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SW-1:0] out_left;
    logic signed [SW-1:0] out_right;
    logic                 block_last;
  } out_item_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_FILTL = 8'b0000_0010,
    ST_FILTR = 8'b0000_0100,
    ST_ENV   = 8'b0000_1000,
    ST_GAIN  = 8'b0001_0000,
    ST_MIX   = 8'b0010_0000,
    ST_OUT   = 8'b0100_0000,
    ST_WAIT  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic load;
    logic filt_l;
    logic filt_r;
    logic env;
    logic gain;
    logic mix;
    logic outp;
  } cmd_t;

endpackage

// File: hw/rtl/sng_ctrl.sv
// Controller state machine of the sidechain noise gate.
// Sequences the datapath one stage per cycle, holding while the output is full; depends on sng_pkg.
module sng_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          out_full,
  output sng_pkg::cmd_t cmd
);
  import sng_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_FILTL;
      ST_FILTL: state_nxt = ST_FILTR;
      ST_FILTR: state_nxt = ST_ENV;
      ST_ENV:   state_nxt = ST_GAIN;
      ST_GAIN:  state_nxt = ST_MIX;
      ST_MIX:   state_nxt = ST_WAIT;
      ST_WAIT:  if (!out_full) state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall   = (state_r != ST_IDLE);
  assign cmd.load   = (state_r == ST_IDLE) && in_valid;
  assign cmd.filt_l = (state_r == ST_FILTL);
  assign cmd.filt_r = (state_r == ST_FILTR);
  assign cmd.env    = (state_r == ST_ENV);
  assign cmd.gain   = (state_r == ST_GAIN);
  assign cmd.mix    = (state_r == ST_MIX);
  assign cmd.outp   = (state_r == ST_OUT);

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("Controller state is not one-hot.");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.filt_l ##1 cmd.filt_r ##1 cmd.env)
    else $error("Processing sequence broken after load.");
  a_out: assert property (@(posedge clk) disable iff (!rst_n) cmd.outp |-> !out_full)
    else $error("Result issued while output register is full.");
endmodule

// File: hw/rtl/sng_datapath.sv
// Datapath of the sidechain noise gate: filter state, envelope, gain and output register.
// Driven by sng_ctrl commands; depends on sng_pkg.
module sng_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sng_pkg::cmd_t        cmd,
  input  sng_pkg::in_item_t    in_item,
  input  logic                 out_stall,
  output logic                 out_full,
  output sng_pkg::out_item_t   out_item,
  input  logic [15:0]          bp_gain,
  input  logic signed [17:0]   bp_fb,
  input  logic [15:0]          att_raw,
  input  logic [15:0]          rel_raw,
  input  logic [19:0]          hold_samples,
  input  logic [22:0]          threshold,
  input  logic [16:0]          floor_raw,
  input  logic [16:0]          mix_raw
);
  import sng_pkg::*;

  localparam logic [16:0] ONE = 17'(1 << FB);
  localparam logic signed [63:0] RND = 64'sd1 <<< (FB - 1);

  in_item_t             item_r;
  logic signed [SW-1:0] lx0_r, lx1_r, rx0_r, rx1_r;
  logic signed [YW-1:0] ly0_r, ly1_r, ry0_r, ry1_r;
  logic [SW-1:0]        absl_r, peak_r, env_r;
  logic [16:0]          gain_r, eff_r;
  logic [19:0]          hold_r;
  logic                 full_r;
  out_item_t            out_r;

  logic [16:0] att, rel, mix, flr;
  assign att = {1'b0, att_raw};
  assign rel = {1'b0, rel_raw};
  assign mix = (mix_raw > ONE) ? ONE : mix_raw;
  assign flr = (floor_raw > ONE) ? ONE : floor_raw;

  function automatic logic signed [63:0] rsh(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + RND;
    return t >>> FB;
  endfunction

  function automatic logic signed [YW-1:0] sat_y(input logic signed [63:0] v);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (YW - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[YW-1:0];
    if (v < lo) return lo[YW-1:0];
    return v[YW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sat_s(input logic signed [63:0] v);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (SW - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[SW-1:0];
    if (v < lo) return lo[SW-1:0];
    return v[SW-1:0];
  endfunction

  logic signed [SW-1:0] fx, fx1;
  logic signed [YW-1:0] fy0, fy1, fy;
  logic signed [63:0]   facc;
  logic [YW-1:0]        fabs;

  always_comb begin
    fx  = cmd.filt_l ? item_r.side_left : item_r.side_right;
    fx1 = cmd.filt_l ? lx1_r : rx1_r;
    fy0 = cmd.filt_l ? ly0_r : ry0_r;
    fy1 = cmd.filt_l ? ly1_r : ry1_r;
    facc = 64'(signed'({1'b0, bp_gain})) * (64'(fx) - 64'(fx1))
         - 64'(bp_fb) * 64'(fy0)
         - (64'(signed'({1'b0, ONE})) - 64'(signed'({1'b0, bp_gain, 1'b0}))) * 64'(fy1);
    fy   = sat_y(rsh(facc));
    fabs = fy[YW-1] ? YW'(-fy) : fy;
  end

  logic [YW-1:0]      peak_w;
  logic [SW-1:0]      peak;
  logic signed [63:0] env_nx;
  always_comb begin
    peak_w = (fabs > {4'd0, absl_r}) ? fabs : {4'd0, absl_r};
    peak   = (peak_w > YW'({SW{1'b1}})) ? {SW{1'b1}} : peak_w[SW-1:0];
    env_nx = 64'(peak_r) + rsh(64'(signed'({1'b0, (peak_r > env_r) ? att : rel}))
             * (64'(env_r) - 64'(peak_r)));
  end

  logic [16:0]        target;
  logic signed [63:0] gain_nx;
  always_comb begin
    if ({1'b0, env_r} >= {2'b0, threshold} || hold_r != 20'd0) target = ONE;
    else target = flr;
    gain_nx = 64'(gain_r) + rsh(64'(signed'({1'b0, (target > gain_r) ? ONE - att : ONE - rel}))
              * (64'(signed'({1'b0, target})) - 64'(signed'({1'b0, gain_r}))));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_item;
    if (cmd.filt_l) begin
      lx1_r <= lx0_r; lx0_r <= item_r.side_left;
      ly1_r <= ly0_r; ly0_r <= fy;
      absl_r <= (fabs > YW'({SW{1'b1}})) ? {SW{1'b1}} : fabs[SW-1:0];
    end
    if (cmd.filt_r) begin
      rx1_r <= rx0_r; rx0_r <= item_r.side_right;
      ry1_r <= ry0_r; ry0_r <= fy;
      peak_r <= peak;
    end
    if (cmd.env) env_r <= env_nx[SW-1:0];
    if (cmd.gain) begin
      if ({1'b0, env_r} >= {2'b0, threshold}) hold_r <= hold_samples;
      else if (hold_r != 20'd0) hold_r <= hold_r - 20'd1;
      gain_r <= gain_nx[16:0];
    end
    if (cmd.mix) eff_r <= 17'(rsh(64'(gain_r) * 64'(mix)) + 64'(ONE) - 64'(mix));
    if (cmd.outp) begin
      out_r.out_left   <= sat_s(rsh(64'(item_r.main_left) * 64'(signed'({1'b0, eff_r}))));
      out_r.out_right  <= sat_s(rsh(64'(item_r.main_right) * 64'(signed'({1'b0, eff_r}))));
      out_r.block_last <= item_r.block_end;
    end
    if (!rst_n) begin
      lx0_r <= '0; lx1_r <= '0; rx0_r <= '0; rx1_r <= '0;
      ly0_r <= '0; ly1_r <= '0; ry0_r <= '0; ry1_r <= '0;
      env_r <= '0; gain_r <= '0; hold_r <= '0; full_r <= 1'b0;
    end else if (cmd.outp) begin
      full_r <= 1'b1;
    end else if (!out_stall) begin
      full_r <= 1'b0;
    end
  end

  assign out_full = full_r && out_stall;
  assign out_item = out_r;

  a_gain: assert property (@(posedge clk) disable iff (!rst_n) gain_r <= ONE)
    else $error("Gate gain above one.");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gain && ({1'b0, env_r} >= {2'b0, threshold}) |=> hold_r == $past(hold_samples))
    else $error("Hold count not reloaded.");
  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    full_r && out_stall && !cmd.outp |=> full_r)
    else $error("Result lost while stalled.");
endmodule

// File: hw/rtl/sidechain_noise_gate.sv
// Top level of the sidechain noise gate: configuration registers, controller and datapath.
// Depends on sng_pkg, sng_ctrl and sng_datapath.
// A stereo sample is accepted while the controller is idle; the controller runs the left
// filter, right filter, envelope, gain smoothing, mix and output scaling one step per cycle
// outside its wait state, registers the result at output scaling and takes no new sample
// until it is idle again. A result that has not been taken holds the controller in its wait
// state before the next result is written. Sample widths are fixed in the package.
module sidechain_noise_gate (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sng_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sng_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import sng_pkg::*;

  logic [15:0]        bp_gain_r, att_r, rel_r;
  logic signed [17:0] bp_fb_r;
  logic [19:0]        hold_r;
  logic [22:0]        thr_r;
  logic [16:0]        floor_r, mix_r;
  logic               vld_r;
  logic               full;
  cmd_t               cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_gain_r <= 16'd2600; bp_fb_r <= -18'sd128000; att_r <= 16'd64190;
      rel_r <= 16'd65529; hold_r <= 20'd2400; thr_r <= 23'd265271;
      floor_r <= 17'd0; mix_r <= 17'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BP_GAIN:   bp_gain_r <= cfg_data[15:0];
        REG_BP_FB:     bp_fb_r   <= cfg_data[17:0];
        REG_ATTACK:    att_r     <= cfg_data[15:0];
        REG_RELEASE:   rel_r     <= cfg_data[15:0];
        REG_HOLD:      hold_r    <= cfg_data[19:0];
        REG_THRESHOLD: thr_r     <= cfg_data[22:0];
        REG_FLOOR:     floor_r   <= cfg_data[16:0];
        REG_MIX:       mix_r     <= cfg_data[16:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (cmd.outp) vld_r <= 1'b1;
    else if (!out_stall) vld_r <= 1'b0;
  end

  assign cfg_ready = 1'b1;
  assign out_valid = vld_r;

  sng_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_full(full), .cmd(cmd)
  );

  sng_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_item(in_data), .out_stall(out_stall),
    .out_full(full), .out_item(out_data), .bp_gain(bp_gain_r), .bp_fb(bp_fb_r),
    .att_raw(att_r), .rel_raw(rel_r), .hold_samples(hold_r), .threshold(thr_r),
    .floor_raw(floor_r), .mix_raw(mix_r)
  );

  a_outv: assert property (@(posedge clk) disable iff (!rst_n) cmd.outp |=> out_valid)
    else $error("Result register not marked valid.");
  a_idle: assert property (@(posedge clk) disable iff (!rst_n) cmd.load |-> !in_stall)
    else $error("Item loaded while stalled.");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Result dropped while stalled.");
endmodule

// File: tb/sidechain_noise_gate_tb.sv
// Testbench for the sidechain noise gate: drives stereo sample transactions, random stalls and
// register writes, and checks each result against a fixed-point gate predictor in a scoreboard.
// Depends on sng_pkg and the sidechain_noise_gate top level.
`timescale 1ns / 100ps

class gate_scoreboard;
  logic [15:0] b0, att_r, rel_r;
  logic signed [17:0] a1;
  logic [19:0] hold_rl, hold_cnt;
  logic [22:0] thresh;
  logic [16:0] floor_g, mix_r;
  longint xl[2], yl[2], xr[2], yr[2];
  longint env, gain;
  sng_pkg::out_item_t pending[$];
  int errors;
  int checked;

  function new();
    errors = 0;
    checked = 0;
    b0 = 16'd2600; a1 = -18'sd128000; att_r = 16'd64190; rel_r = 16'd65529;
    hold_rl = 20'd2400; thresh = 23'd265271; floor_g = 17'd0; mix_r = 17'd65536;
    xl = '{0, 0}; yl = '{0, 0}; xr = '{0, 0}; yr = '{0, 0};
    env = 0; gain = 0; hold_cnt = 20'd0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      sng_pkg::REG_BP_GAIN:   b0 = v[15:0];
      sng_pkg::REG_BP_FB:     a1 = v[17:0];
      sng_pkg::REG_ATTACK:    att_r = v[15:0];
      sng_pkg::REG_RELEASE:   rel_r = v[15:0];
      sng_pkg::REG_HOLD:      hold_rl = v[19:0];
      sng_pkg::REG_THRESHOLD: thresh = v[22:0];
      sng_pkg::REG_FLOOR:     floor_g = v[16:0];
      sng_pkg::REG_MIX:       mix_r = v[16:0];
      default: ;
    endcase
  endfunction

  function longint rnd(longint v);
    longint t;
    t = v + 32768;
    return t >>> 16;
  endfunction

  function longint satw(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function longint clamp1(longint v);
    return v > 65536 ? 65536 : v;
  endfunction

  function longint biquad(longint x, ref longint xd[2], ref longint yd[2]);
    longint acc, y, a2, g;
    g = b0;
    a2 = 65536 - 2 * g;
    acc = g * (x - xd[1]) - longint'(a1) * yd[0] - a2 * yd[1];
    y = satw(rnd(acc), sng_pkg::YW);
    xd[1] = xd[0]; xd[0] = x;
    yd[1] = yd[0]; yd[0] = y;
    return y;
  endfunction

  function void note_input(sng_pkg::in_item_t it);
    longint pl, pr, peak, att, rel, mix, target, coef, eff;
    sng_pkg::out_item_t res;
    att = clamp1(att_r);
    rel = clamp1(rel_r);
    mix = clamp1(mix_r);
    pl = biquad(longint'(it.side_left), xl, yl);
    pr = biquad(longint'(it.side_right), xr, yr);
    if (pl < 0) pl = -pl;
    if (pr < 0) pr = -pr;
    peak = pl > pr ? pl : pr;
    if (peak > 64'sd16777215) peak = 16777215;
    if (peak > env) env = peak + rnd(att * (env - peak));
    else env = peak + rnd(rel * (env - peak));
    if (env >= longint'(thresh)) begin
      target = 65536;
      hold_cnt = hold_rl;
    end else if (hold_cnt > 0) begin
      target = 65536;
      hold_cnt--;
    end else begin
      target = clamp1(floor_g);
    end
    coef = (target > gain) ? (65536 - att) : (65536 - rel);
    gain += rnd(coef * (target - gain));
    eff = rnd(gain * mix) + 65536 - mix;
    res.out_left = 24'(satw(rnd(longint'(it.main_left) * eff), sng_pkg::SW));
    res.out_right = 24'(satw(rnd(longint'(it.main_right) * eff), sng_pkg::SW));
    res.block_last = it.block_end;
    pending.push_back(res);
  endfunction

  function void check_result(sng_pkg::out_item_t got);
    sng_pkg::out_item_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    checked++;
    if (got.out_left !== exp_r.out_left) begin
      $display("%0t: out_left expected %0d actual %0d", $time, exp_r.out_left, got.out_left);
      errors++;
    end
    if (got.out_right !== exp_r.out_right) begin
      $display("%0t: out_right expected %0d actual %0d", $time, exp_r.out_right, got.out_right);
      errors++;
    end
    if (got.block_last !== exp_r.block_last) begin
      $display("%0t: block_last expected %0b actual %0b", $time, exp_r.block_last,
               got.block_last);
      errors++;
    end
  endfunction
endclass

module sidechain_noise_gate_tb;
  import sng_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  gate_scoreboard sb = new();
  int cycles = 0;
  bit calm = 0;
  bit hold_off = 0;
  int sent = 0;
  localparam int LIMIT = 400000;

  sidechain_noise_gate i_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  always @(negedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= !calm && ($urandom_range(99) < 17);
  end

  task automatic send(in_item_t it);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 17) @(negedge clk);
    in_data <= it;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic in_item_t rand_item(int mode);
    in_item_t it;
    it.main_left = SW'($urandom);
    it.main_right = SW'($urandom);
    it.side_left = SW'($urandom);
    it.side_right = SW'($urandom);
    if (mode == 1) begin
      it.side_left = $signed(it.side_left) >>> $urandom_range(14);
      it.side_right = $signed(it.side_right) >>> $urandom_range(14);
    end else if (mode == 2) begin
      it.side_left = '0;
      it.side_right = $signed(it.side_right) >>> 16;
    end
    it.block_end = ($urandom_range(15) == 0);
    return it;
  endfunction

  task automatic random_cfg();
    write_cfg(REG_BP_GAIN, $urandom_range(65535));
    write_cfg(REG_BP_FB, $urandom);
    write_cfg(REG_ATTACK, $urandom_range(65535));
    write_cfg(REG_RELEASE, $urandom_range(65535));
    write_cfg(REG_HOLD, $urandom_range(40));
    write_cfg(REG_THRESHOLD, $urandom_range(8388607) >> $urandom_range(16));
    write_cfg(REG_FLOOR, $urandom_range(70000));
    write_cfg(REG_MIX, $urandom_range(70000));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed extremes at reset settings, then with saturating coefficients.
    send('{24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 1'b1});
    send('{24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1'b0});
    send('{24'sh000000, 24'shFFFFFF, 24'sh000001, 24'shFFFFFF, 1'b1});
    send('{24'sh400000, 24'shC00000, 24'sh000000, 24'sh000000, 1'b0});
    drain();
    write_cfg(REG_BP_GAIN, 65535);
    write_cfg(REG_BP_FB, 32'h1FFFF);
    write_cfg(REG_ATTACK, 65535);
    write_cfg(REG_RELEASE, 0);
    write_cfg(REG_HOLD, 0);
    write_cfg(REG_THRESHOLD, 0);
    write_cfg(REG_FLOOR, 65536);
    write_cfg(REG_MIX, 0);
    for (int i = 0; i < 6; i++)
      send('{24'sh7FFFFF, 24'sh800000, (i[0] ? 24'sh7FFFFF : 24'sh800000),
             24'sh7FFFFF, i[0]});
    drain();
    write_cfg(REG_BP_FB, 32'h20000);
    write_cfg(REG_ATTACK, 0);
    write_cfg(REG_RELEASE, 65535);
    write_cfg(REG_HOLD, 32'hFFFFF);
    write_cfg(REG_THRESHOLD, 32'h7FFFFF);
    write_cfg(REG_FLOOR, 32'h1FFFF);
    write_cfg(REG_MIX, 32'h1FFFF);
    write_cfg(REG_MIX, 65536);
    for (int i = 0; i < 6; i++) send(rand_item(0));
    drain();
    write_cfg(REG_FLOOR, 0);

    for (int phase = 0; phase < 8; phase++) begin
      random_cfg();
      calm = (phase == 3);
      if (phase == 5) begin
        fork
          begin
            hold_off = 1;
            repeat (200) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      for (int i = 0; i < 50; i++) begin
        send(rand_item($urandom_range(2)));
        if (i == 25) drain();
      end
      calm = 0;
      drain();
    end

    drain();
    $display("Ran %0d sample transactions, %0d results checked, over several register sets.",
             sent, sb.checked);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
